>>> rtl/core/wph_pkg.sv
package wph_pkg;

  // Header layout
  localparam int unsigned HdrLen = 44;
  localparam logic [5:0]  LastPos = 6'(HdrLen - 1);

  // Chunk tags, read big-endian
  localparam logic [31:0] TagRiff = 32'h5249_4646;
  localparam logic [31:0] TagWave = 32'h5741_5645;
  localparam logic [31:0] TagFmt  = 32'h666d_7420;
  localparam logic [31:0] TagData = 32'h6461_7461;

  // Fixed values
  localparam logic [31:0] RiffBase = 32'd36;
  localparam logic [31:0] FmtLen   = 32'd16;
  localparam logic [15:0] PcmCode  = 16'd1;
  localparam logic [15:0] ChMono   = 16'd1;
  localparam logic [15:0] ChStereo = 16'd2;
  localparam logic [15:0] Bits8    = 16'd8;
  localparam logic [15:0] Bits16   = 16'd16;

  // Gathered header fields
  typedef struct packed {
    logic [31:0] riff_tag;
    logic [31:0] riff_size;
    logic [31:0] wave_tag;
    logic [31:0] format_tag;
    logic [31:0] format_size;
    logic [15:0] audio_code;
    logic [15:0] channel_count;
    logic [31:0] rate_value;
    logic [31:0] bytes_per_second;
    logic [15:0] frame_bytes;
    logic [15:0] bits_per_sample;
    logic [31:0] data_tag;
    logic [31:0] data_size;
  } wph_fields_t;

  // One verdict
  typedef struct packed {
    logic        header_ok;
    logic [31:0] sample_rate;
    logic        sixteen_bit;
    logic        stereo;
  } wph_result_t;

  // Place byte b at little-endian byte k of v
  function automatic logic [31:0] put_le32(logic [31:0] v, logic [1:0] k, logic [7:0] b);
    logic [31:0] r;
    r = v;
    for (int i = 0; i < 4; i++) begin
      if (k == 2'(i)) r[8*i +: 8] = b;
    end
    return r;
  endfunction

  // Place byte b at big-endian byte k of v
  function automatic logic [31:0] put_be32(logic [31:0] v, logic [1:0] k, logic [7:0] b);
    return put_le32(v, ~k, b);
  endfunction

  // Place byte b at little-endian byte k of a 16-bit v
  function automatic logic [15:0] put_le16(logic [15:0] v, logic k, logic [7:0] b);
    logic [15:0] r;
    r = v;
    if (k) r[15:8] = b;
    else   r[7:0]  = b;
    return r;
  endfunction

endpackage

>>> rtl/core/wph_in_if.sv
interface wph_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;
  logic       start_flag;

  modport source (output valid, output header_byte, output start_flag, input ready);
  modport sink   (input valid, input header_byte, input start_flag, output ready);
endinterface

>>> rtl/core/wph_out_if.sv
interface wph_out_if;
  logic        valid;
  logic        ready;
  logic        header_ok;
  logic [31:0] sample_rate;
  logic        sixteen_bit;
  logic        stereo;

  modport source (output valid, output header_ok, output sample_rate,
                  output sixteen_bit, output stereo, input ready);
  modport sink   (input valid, input header_ok, input sample_rate,
                  input sixteen_bit, input stereo, output ready);
endinterface

>>> rtl/core/wph_verdict.sv
module wph_verdict (
  input  wph_pkg::wph_fields_t fields,
  output wph_pkg::wph_result_t result
);
  import wph_pkg::*;

  logic        ch_ok, bits_ok, stereo, b16;
  logic [2:0]  shift;
  logic [31:0] bps_exp;
  logic [15:0] align_exp;
  logic [31:0] riff_min;
  logic        ok;

  // Channel and width checks
  assign stereo  = (fields.channel_count == ChStereo);
  assign b16     = (fields.bits_per_sample == Bits16);
  assign ch_ok   = (fields.channel_count == ChMono) || stereo;
  assign bits_ok = (fields.bits_per_sample == Bits8) || b16;

  // rate*ch*bits is a shift once ch and bits are legal; wraps at 32 bits, then /8
  assign shift     = 3'd3 + {2'b00, stereo} + {2'b00, b16};
  assign bps_exp   = 32'(fields.rate_value << shift) >> 3;
  assign align_exp = 16'(16'd1 << (shift - 3'd3));

  assign riff_min = RiffBase + fields.data_size;

  // Combined verdict
  assign ok = (fields.riff_tag == TagRiff) &&
              (fields.riff_size >= riff_min) &&
              (fields.wave_tag == TagWave) &&
              (fields.format_tag == TagFmt) &&
              (fields.format_size == FmtLen) &&
              (fields.audio_code == PcmCode) &&
              ch_ok && bits_ok &&
              (fields.bytes_per_second == bps_exp) &&
              (fields.frame_bytes == align_exp) &&
              (fields.data_tag == TagData);

  assign result.header_ok   = ok;
  assign result.sample_rate = ok ? fields.rate_value : 32'd0;
  assign result.sixteen_bit = ok && b16;
  assign result.stereo      = ok && stereo;

endmodule

>>> rtl/core/wav_pcm_header_checker.sv
// Channel  Dir  Payload                                    Item
// bytes    in   header_byte[7:0], start_flag               one header byte
// result   out  header_ok, sample_rate[31:0],              one verdict per
//               sixteen_bit, stereo                        44 bytes
//
// One byte per cycle sustained while no result stall holds the input; a
// byte goes through an input register and the capture/verdict logic, and
// the verdict of the ending byte is registered. rst is synchronous, active
// high, and clears the byte count and the valid flags. A stalled result
// holds the input register only on the byte that ends the next header.
module wav_pcm_header_checker (
  input logic      clk,
  input logic      rst,
  wph_in_if.sink   bytes,
  wph_out_if.source result
);
  import wph_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_start;
  logic [5:0]  byte_position;
  logic [5:0]  byte_position_next;
  logic [5:0]  pos;
  logic        last;
  logic        advance;
  wph_fields_t fields;
  wph_fields_t fields_next;
  wph_result_t verdict;
  wph_result_t res;
  logic        res_valid;

  // Position of the registered byte
  assign pos     = in_start ? 6'd0 : byte_position;
  assign last    = (pos == LastPos);
  assign advance = in_valid && (!last || !res_valid || result.ready);

  assign bytes.ready = !in_valid || advance;
  assign byte_position_next = last ? 6'd0 : pos + 6'd1;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (bytes.ready) begin
      in_valid <= bytes.valid;
    end
    if (bytes.ready && bytes.valid) begin
      in_byte  <= bytes.header_byte;
      in_start <= bytes.start_flag;
    end
  end

  // Capture the byte into its field
  always_comb begin
    fields_next = fields;
    if (pos < 6'd4)       fields_next.riff_tag = put_be32(fields.riff_tag, pos[1:0], in_byte);
    else if (pos < 6'd8)  fields_next.riff_size = put_le32(fields.riff_size, pos[1:0], in_byte);
    else if (pos < 6'd12) fields_next.wave_tag = put_be32(fields.wave_tag, pos[1:0], in_byte);
    else if (pos < 6'd16) fields_next.format_tag =
                            put_be32(fields.format_tag, pos[1:0], in_byte);
    else if (pos < 6'd20) fields_next.format_size =
                            put_le32(fields.format_size, pos[1:0], in_byte);
    else if (pos < 6'd22) fields_next.audio_code =
                            put_le16(fields.audio_code, pos[0], in_byte);
    else if (pos < 6'd24) fields_next.channel_count =
                            put_le16(fields.channel_count, pos[0], in_byte);
    else if (pos < 6'd28) fields_next.rate_value =
                            put_le32(fields.rate_value, pos[1:0], in_byte);
    else if (pos < 6'd32) fields_next.bytes_per_second =
                            put_le32(fields.bytes_per_second, pos[1:0], in_byte);
    else if (pos < 6'd34) fields_next.frame_bytes =
                            put_le16(fields.frame_bytes, pos[0], in_byte);
    else if (pos < 6'd36) fields_next.bits_per_sample =
                            put_le16(fields.bits_per_sample, pos[0], in_byte);
    else if (pos < 6'd40) fields_next.data_tag = put_be32(fields.data_tag, pos[1:0], in_byte);
    else                  fields_next.data_size =
                            put_le32(fields.data_size, pos[1:0], in_byte);
  end

  wph_verdict u_verdict (
    .fields (fields_next),
    .result (verdict)
  );

  // Field and position registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 6'd0;
    end else if (advance) begin
      byte_position <= byte_position_next;
    end
    if (advance) begin
      fields <= fields_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && last) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
    if (advance && last) begin
      res <= verdict;
    end
  end

  assign result.valid       = res_valid;
  assign result.header_ok   = res.header_ok;
  assign result.sample_rate = res.sample_rate;
  assign result.sixteen_bit = res.sixteen_bit;
  assign result.stereo      = res.stereo;

`ifndef NO_ASSERTIONS
  // Count stays inside the header
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= LastPos) else $error("byte position out of range");

  // Ending byte always yields a result
  a_last_res: assert property (@(posedge clk) disable iff (rst)
    advance && last |=> res_valid) else $error("verdict lost");

  // Failed verdict carries zeros
  a_zero_fail: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.header_ok |->
      res.sample_rate == 32'd0 && !res.sixteen_bit && !res.stereo)
    else $error("failed verdict has nonzero fields");

  // A stall happens only on the ending byte with a full result slot
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |-> last && res_valid && !result.ready)
    else $error("unexpected input stall");
`endif

endmodule

>>> dv/tb_wav_pcm_header_checker.sv
module tb_wav_pcm_header_checker;
  timeunit 1ns;
  timeprecision 1ps;

  import wph_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned ItemTarget = 1550;
  localparam wph_result_t NoVerdict = '0;

  // How a header is introduced on the byte stream
  typedef enum logic [1:0] {
    LEAD_FLAG,   // start_flag on the first byte
    LEAD_NONE,   // no start_flag, relies on the byte count
    LEAD_JUNK    // partial junk header, then start_flag restarts
  } lead_t;

  typedef struct {
    wph_fields_t fields;
    lead_t       lead;
    logic        typed;
    wph_result_t want;
  } hdr_row_t;

  logic clk = 1'b0;
  logic rst;

  wph_in_if  bytes_if ();
  wph_out_if result_if ();

  wav_pcm_header_checker DUT (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes_if),
    .result (result_if)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [5:0]  hdr_pos;
  wph_fields_t gathered;
  wph_result_t verdict_q[$];

  // Directed-row override for the verdict of the current last byte
  logic        typed_on;
  wph_result_t typed_res;

  logic        calm;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned verdicts_seen = 0;
  int unsigned passes_seen = 0;
  int unsigned bytes_sent = 0;
  int unsigned headers_sent = 0;
  hdr_row_t    dir_rows[$];
  logic [31:0] common_rates[6] = '{32'd8000, 32'd11025, 32'd22050,
                                   32'd44100, 32'd48000, 32'd96000};

  // Bit offset of header byte p inside the packed field struct. The struct
  // follows the header layout; tags are big-endian, the rest little-endian.
  function automatic int unsigned byte_lsb(int unsigned p);
    int unsigned s, n;
    if (p < 4 || (p >= 8 && p < 16) || (p >= 36 && p < 40)) return 344 - 8 * p;
    n = ((p >= 20 && p < 24) || (p >= 32 && p < 36)) ? 2 : 4;
    s = (n == 2) ? (p & ~32'd1) : (p & ~32'd3);
    return 352 - 8 * (s + n) + 8 * (p - s);
  endfunction

  // Consistent PCM header for the given format
  function automatic wph_fields_t good_hdr(logic [31:0] rate, logic [15:0] ch,
                                           logic [15:0] bits, logic [31:0] dsize);
    wph_fields_t f;
    logic [31:0] prod;
    prod = rate * {16'h0, ch} * {16'h0, bits};
    f.riff_tag         = TagRiff;
    f.riff_size        = RiffBase + dsize;
    f.wave_tag         = TagWave;
    f.format_tag       = TagFmt;
    f.format_size      = FmtLen;
    f.audio_code       = PcmCode;
    f.channel_count    = ch;
    f.rate_value       = rate;
    f.bytes_per_second = prod >> 3;
    f.frame_bytes      = 16'(({16'h0, ch} * {16'h0, bits}) >> 3);
    f.bits_per_sample  = bits;
    f.data_tag         = TagData;
    f.data_size        = dsize;
    return f;
  endfunction

  // Gather one byte; on the last byte of a header produce the verdict
  task automatic take_byte(input logic [7:0] b, input logic sf,
                           output logic fire, output wph_result_t r);
    logic        ok;
    logic [31:0] ch32, bits32, lim, rate_prod, ch_prod;
    if (sf) hdr_pos = '0;
    gathered[byte_lsb(hdr_pos) +: 8] = b;
    fire = (hdr_pos == LastPos);
    r = NoVerdict;
    if (!fire) begin
      hdr_pos = hdr_pos + 6'd1;
    end else begin
      hdr_pos   = '0;
      ch32      = {16'h0, gathered.channel_count};
      bits32    = {16'h0, gathered.bits_per_sample};
      rate_prod = gathered.rate_value * ch32 * bits32;
      ch_prod   = ch32 * bits32;
      lim       = RiffBase + gathered.data_size;
      ok = (gathered.riff_tag == TagRiff) && (gathered.riff_size >= lim) &&
           (gathered.wave_tag == TagWave) && (gathered.format_tag == TagFmt) &&
           (gathered.format_size == FmtLen) && (gathered.audio_code == PcmCode) &&
           (gathered.channel_count == ChMono || gathered.channel_count == ChStereo) &&
           (gathered.bytes_per_second == (rate_prod >> 3)) &&
           ({16'h0, gathered.frame_bytes} == (ch_prod >> 3)) &&
           (gathered.bits_per_sample == Bits8 || gathered.bits_per_sample == Bits16) &&
           (gathered.data_tag == TagData);
      if (ok) begin
        r.header_ok   = 1'b1;
        r.sample_rate = gathered.rate_value;
        r.sixteen_bit = (gathered.bits_per_sample == Bits16);
        r.stereo      = (gathered.channel_count == ChStereo);
      end
    end
  endtask

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Idle length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one byte at the falling edge and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic sf);
    int unsigned g;
    g = pick_gap();
    if (g > 0) begin
      bytes_if.valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    bytes_if.valid       = 1'b1;
    bytes_if.header_byte = b;
    bytes_if.start_flag  = sf;
    do @(posedge clk); while (!bytes_if.ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_header(input wph_fields_t f, input lead_t lead,
                             input logic typed, input wph_result_t want);
    int unsigned junk;
    if (lead == LEAD_JUNK) begin
      junk = $urandom_range(1, HdrLen - 1);
      repeat (junk) send_byte(8'($urandom), 1'b0);
    end
    typed_res = want;
    for (int unsigned p = 0; p < HdrLen; p++) begin
      typed_on = typed && (p == HdrLen - 1);
      send_byte(f[byte_lsb(p) +: 8], (p == 0) && (lead != LEAD_NONE));
    end
    typed_on = 1'b0;
    headers_sent++;
  endtask

  // Hold off the sender until every pending verdict has come out
  task automatic wait_results();
    if (verdict_q.size() != 0) begin
      bytes_if.valid = 1'b0;
      while (verdict_q.size() != 0) @(negedge clk);
    end
  endtask

  task automatic add_row(input wph_fields_t f, input lead_t lead,
                         input logic typed, input wph_result_t want);
    hdr_row_t row;
    row.fields = f;
    row.lead   = lead;
    row.typed  = typed;
    row.want   = want;
    dir_rows.push_back(row);
  endtask

  // Monitor: check verdicts first, then predict from accepted bytes
  always @(posedge clk) begin
    wph_result_t got, want_r, pred;
    logic        fire, busy;
    if (rst) begin
      hdr_pos     = '0;
      gathered    = '0;
      idle_cycles = 0;
    end else begin
      busy = 1'b0;
      if (result_if.valid && result_if.ready) begin
        busy            = 1'b1;
        got.header_ok   = result_if.header_ok;
        got.sample_rate = result_if.sample_rate;
        got.sixteen_bit = result_if.sixteen_bit;
        got.stereo      = result_if.stereo;
        verdicts_seen++;
        if (got.header_ok === 1'b1) passes_seen++;
        if (verdict_q.size() == 0) begin
          flag_error($sformatf("verdict with none pending: ok=%0b rate=%0d 16b=%0b st=%0b",
                               got.header_ok, got.sample_rate, got.sixteen_bit, got.stereo));
        end else begin
          want_r = verdict_q.pop_front();
          if (got.header_ok !== want_r.header_ok || got.sample_rate !== want_r.sample_rate ||
              got.sixteen_bit !== want_r.sixteen_bit || got.stereo !== want_r.stereo) begin
            flag_error($sformatf({"verdict %0d: exp ok=%0b rate=%0d 16b=%0b st=%0b,",
                                  " got ok=%0b rate=%0d 16b=%0b st=%0b"}, verdicts_seen,
                                 want_r.header_ok, want_r.sample_rate, want_r.sixteen_bit,
                                 want_r.stereo, got.header_ok, got.sample_rate,
                                 got.sixteen_bit, got.stereo));
          end
        end
      end
      if (bytes_if.valid && bytes_if.ready) begin
        busy = 1'b1;
        take_byte(bytes_if.header_byte, bytes_if.start_flag, fire, pred);
        if (fire) verdict_q.push_back(typed_on ? typed_res : pred);
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
    end
  end

  // Receiver: random stalls after ready cycles
  initial begin
    int unsigned hold;
    result_if.ready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        result_if.ready = 1'b0;
        hold--;
      end else begin
        result_if.ready = 1'b1;
        hold = pick_gap();
      end
    end
  end

  // Watchdog on cycles with no item moving on either channel
  initial begin
    wait (idle_cycles >= IdleLimit);
    $display("Stalled for %0d cycles with %0d verdicts pending", idle_cycles,
             verdict_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    wph_fields_t f;
    lead_t       lead;
    int unsigned hdr_idx, n, pick;
    bytes_if.valid       = 1'b0;
    bytes_if.header_byte = '0;
    bytes_if.start_flag  = 1'b0;
    typed_on             = 1'b0;
    typed_res            = NoVerdict;
    calm                 = 1'b0;
    rst                  = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed headers: good formats, each failing check, extremes, restarts
    add_row(good_hdr(32'd44100, ChStereo, Bits16, 32'd1000), LEAD_NONE, 1'b1,
            '{header_ok: 1'b1, sample_rate: 32'd44100, sixteen_bit: 1'b1, stereo: 1'b1});
    add_row(good_hdr(32'd8000, ChMono, Bits8, 32'd0), LEAD_FLAG, 1'b1,
            '{header_ok: 1'b1, sample_rate: 32'd8000, sixteen_bit: 1'b0, stereo: 1'b0});
    add_row(good_hdr(32'd48000, ChStereo, Bits8, 32'h0001_0000), LEAD_NONE, 1'b0, NoVerdict);
    // product of rate, channels and bits wraps
    add_row(good_hdr(32'hFFFF_FFFF, ChMono, Bits16, 32'd5), LEAD_FLAG, 1'b0, NoVerdict);
    // 36 + data size wraps, riff size at its maximum
    f = good_hdr(32'd0, ChStereo, Bits16, 32'hFFFF_FFFF);
    f.riff_size = '1;
    add_row(f, LEAD_NONE, 1'b0, NoVerdict);
    f = good_hdr(32'd44100, ChStereo, Bits16, 32'd64);
    f.riff_tag = 32'h5249_4647;
    add_row(f, LEAD_FLAG, 1'b1, NoVerdict);
    f = good_hdr(32'd44100, ChStereo, Bits16, 32'd64);
    f.wave_tag = 32'hD741_5645;
    add_row(f, LEAD_NONE, 1'b1, NoVerdict);
    f = good_hdr(32'd44100, ChStereo, Bits16, 32'd64);
    f.format_tag = 32'h666d_7400;
    add_row(f, LEAD_FLAG, 1'b1, NoVerdict);
    f = good_hdr(32'd44100, ChStereo, Bits16, 32'd64);
    f.data_tag = 32'h6461_7460;
    add_row(f, LEAD_NONE, 1'b1, NoVerdict);
    f = good_hdr(32'd44100, ChStereo, Bits16, 32'd64);
    f.format_size = 32'd18;
    add_row(f, LEAD_FLAG, 1'b1, NoVerdict);
    f = good_hdr(32'd44100, ChStereo, Bits16, 32'd64);
    f.audio_code = 16'hFFFF;
    add_row(f, LEAD_NONE, 1'b1, NoVerdict);
    add_row(good_hdr(32'd22050, 16'd0, Bits16, 32'd10), LEAD_FLAG, 1'b1, NoVerdict);
    add_row(good_hdr(32'd22050, 16'd3, Bits16, 32'd10), LEAD_NONE, 1'b1, NoVerdict);
    add_row(good_hdr(32'd22050, ChStereo, 16'd24, 32'd10), LEAD_FLAG, 1'b1, NoVerdict);
    f = good_hdr(32'd22050, ChStereo, Bits16, 32'd10);
    f.bytes_per_second = f.bytes_per_second + 32'd1;
    add_row(f, LEAD_NONE, 1'b1, NoVerdict);
    f = good_hdr(32'd22050, ChStereo, Bits16, 32'd10);
    f.frame_bytes = f.frame_bytes - 16'd1;
    add_row(f, LEAD_FLAG, 1'b1, NoVerdict);
    // riff size one short of 36 + data size
    f = good_hdr(32'd22050, ChMono, Bits8, 32'd500);
    f.riff_size = f.riff_size - 32'd1;
    add_row(f, LEAD_NONE, 1'b1, NoVerdict);
    add_row('1, LEAD_FLAG, 1'b1, NoVerdict);
    add_row('0, LEAD_JUNK, 1'b1, NoVerdict);
    add_row(good_hdr(32'd96000, ChMono, Bits16, 32'd12345), LEAD_JUNK, 1'b0, NoVerdict);
    add_row(good_hdr(32'd11025, ChStereo, Bits8, 32'd7), LEAD_NONE, 1'b0, NoVerdict);

    foreach (dir_rows[i]) begin
      send_header(dir_rows[i].fields, dir_rows[i].lead, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random headers until the byte budget is used: mostly well formed,
    // some corrupted, some noise
    hdr_idx = 0;
    while (bytes_sent < ItemTarget) begin
      calm = (hdr_idx % 9 == 4);
      if (hdr_idx % 10 == 5) wait_results();
      if ($urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 50);
        repeat (n) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end
      pick = $urandom_range(0, 9);
      if (pick == 9) begin
        for (int i = 0; i < 11; i++) f[32 * i +: 32] = $urandom();
      end else begin
        f = good_hdr(($urandom_range(0, 1) == 0) ? common_rates[$urandom_range(0, 5)]
                                                   : 32'($urandom),
                     ($urandom_range(0, 1) == 0) ? ChMono : ChStereo,
                     ($urandom_range(0, 1) == 0) ? Bits8 : Bits16,
                     ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 65535))
                                                   : 32'($urandom));
        if (pick >= 6) begin
          n = $urandom_range(0, 351);
          f[n] = ~f[n];
        end
      end
      pick = $urandom_range(0, 9);
      if (pick < 5)      lead = LEAD_FLAG;
      else if (pick < 8) lead = LEAD_NONE;
      else               lead = LEAD_JUNK;
      send_header(f, lead, 1'b0, NoVerdict);
      hdr_idx++;
    end
    calm = 1'b0;

    // Drain, then watch a few more cycles for stray verdicts
    bytes_if.valid = 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (verdict_q.size() != 0) flag_error($sformatf("%0d verdicts never came",
                                                    verdict_q.size()));

    $display("Sent %0d headers (%0d directed) in %0d bytes with stalls on both sides",
             headers_sent, dir_rows.size(), bytes_sent);
    $display("Checked %0d verdicts, %0d passing; mismatches: %0d",
             verdicts_seen, passes_seen, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
